// ----- sv/stxetx_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the STX/ETX framer.
package stxetx_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TOTAL_W   = 9;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned BURST_MAX = 6;
  localparam int unsigned CNT_W     = $clog2(BURST_MAX + 1);

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 8'd1;

  localparam logic [BYTE_W-1:0]  START_BYTE_RST = 8'h02;
  localparam logic [BYTE_W-1:0]  END_BYTE_RST   = 8'h03;
  localparam logic [TOTAL_W-1:0] TOTAL_RST      = 9'd6;

  localparam logic [BYTE_W-1:0]  LEN_OVERHEAD   = 8'd4;
  localparam logic [TOTAL_W-1:0] TOTAL_OVERHEAD = 9'd6;
  localparam logic [15:0]        CRC_POLY       = 16'h8408;

  localparam logic CMD_HEADER  = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  typedef struct packed {
    logic [BURST_MAX-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]                 count;
    logic                             has_end;
    logic [TOTAL_W-1:0]               total;
  } burst_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/stxetx_item_if.sv -----
// Input item channel: header or payload word.
interface stxetx_item_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] msg_type;
  logic [7:0] pay_len;
  logic [7:0] data_byte;

  modport source (output valid, cmd, msg_type, pay_len, data_byte, input ready);
  modport sink   (input valid, cmd, msg_type, pay_len, data_byte, output ready);
endinterface

// ----- sv/stxetx_result_if.sv -----
// Output channel: one serialized frame byte per word.
interface stxetx_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic [8:0] frame_total;
  logic       last;

  modport source (output valid, out_byte, frame_end, frame_total, last, input ready);
  modport sink   (input valid, out_byte, frame_end, frame_total, last, output ready);
endinterface

// ----- sv/stxetx_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface stxetx_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/stx_etx_crc16_framer.sv -----
// Top level of the STX/ETX frame builder with CRC-16 trailer.
// The first byte of a word appears in the cycle after the word is accepted.
// Throughput: one output byte per cycle while result.ready is high, and then a payload
// word is taken every cycle; a header emits 3 or 6 bytes and a closing payload word 4.
// The result register holds one word's bytes; the next word enters as its last byte leaves.
// Reset (rst, synchronous): no frame open, delimiters 0x02/0x03, output empty.
module stx_etx_crc16_framer
  import stxetx_pkg::*;
(
  input logic            clk,
  input logic            rst,
  stxetx_item_if.sink    item,
  stxetx_result_if.source result,
  stxetx_cfg_if.sink     cfg
);

  burst_t burst;
  logic   take;
  logic   fire;

  assign item.ready = take;
  assign fire       = item.valid && take;
  assign cfg.ready  = 1'b1;

  stxetx_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .cmd       (item.cmd),
    .msg_type  (item.msg_type),
    .pay_len   (item.pay_len),
    .data_byte (item.data_byte),
    .cfg_fire  (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .burst     (burst)
  );

  stxetx_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .burst         (burst),
    .take          (take),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .out_byte      (result.out_byte),
    .out_frame_end (result.frame_end),
    .out_total     (result.frame_total),
    .out_last      (result.last)
  );

endmodule

// ----- sv/stxetx_core.sv -----
// Frame state, CRC update and burst build for one accepted word.
module stxetx_core
  import stxetx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic                 cmd,
  input  logic [BYTE_W-1:0]    msg_type,
  input  logic [BYTE_W-1:0]    pay_len,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic                 cfg_fire,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output burst_t               burst
);

  logic               in_frame, in_frame_next;
  logic [BYTE_W-1:0]  bytes_left, bytes_left_next;
  logic [15:0]        crc_acc, crc_acc_next;
  logic [TOTAL_W-1:0] frame_len, frame_len_next;
  logic [BYTE_W-1:0]  start_byte, end_byte;

  logic [BYTE_W-1:0]  len_byte;
  logic [TOTAL_W-1:0] hdr_total;
  logic [15:0]        hdr_crc_a, hdr_crc, pay_crc;
  logic [BYTE_W-1:0]  left_dec;

  assign len_byte  = pay_len + LEN_OVERHEAD;
  assign hdr_total = {1'b0, pay_len} + TOTAL_OVERHEAD;
  assign hdr_crc_a = crc_byte(16'h0000, len_byte);
  assign hdr_crc   = crc_byte(hdr_crc_a, msg_type);
  assign pay_crc   = crc_byte(crc_acc, data_byte);
  assign left_dec  = bytes_left - 8'd1;

  always_comb begin
    in_frame_next   = in_frame;
    bytes_left_next = bytes_left;
    crc_acc_next    = crc_acc;
    frame_len_next  = frame_len;
    burst           = '0;
    burst.total     = frame_len;
    unique case (cmd)
      CMD_HEADER: begin
        burst.bytes[0] = start_byte;
        burst.bytes[1] = len_byte;
        burst.bytes[2] = msg_type;
        burst.bytes[3] = hdr_crc[7:0];
        burst.bytes[4] = hdr_crc[15:8];
        burst.bytes[5] = end_byte;
        burst.total    = hdr_total;
        burst.has_end  = (pay_len == '0);
        burst.count    = burst.has_end ? CNT_W'(6) : CNT_W'(3);
        crc_acc_next    = hdr_crc;
        frame_len_next  = hdr_total;
        in_frame_next   = !burst.has_end;
        bytes_left_next = pay_len;
      end
      CMD_PAYLOAD: begin
        if (in_frame) begin
          burst.bytes[0] = data_byte;
          burst.bytes[1] = pay_crc[7:0];
          burst.bytes[2] = pay_crc[15:8];
          burst.bytes[3] = end_byte;
          burst.has_end  = (left_dec == '0);
          burst.count    = burst.has_end ? CNT_W'(4) : CNT_W'(1);
          crc_acc_next    = pay_crc;
          in_frame_next   = !burst.has_end;
          bytes_left_next = left_dec;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      bytes_left <= '0;
      crc_acc    <= '0;
      frame_len  <= TOTAL_RST;
    end else if (fire) begin
      in_frame   <= in_frame_next;
      bytes_left <= bytes_left_next;
      crc_acc    <= crc_acc_next;
      frame_len  <= frame_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RST;
      end_byte   <= END_BYTE_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_START_BYTE: start_byte <= cfg_data;
        REG_END_BYTE:   end_byte   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/stxetx_emit.sv -----
// Result register that holds one burst and shifts it out one byte per word.
module stxetx_emit
  import stxetx_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  burst_t             burst,
  output logic               take,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_frame_end,
  output logic [TOTAL_W-1:0] out_total,
  output logic               out_last
);

  logic                             vld;
  logic [CNT_W-1:0]                 left;
  logic [BURST_MAX-1:0][BYTE_W-1:0] shreg;
  logic                             has_end;
  logic [TOTAL_W-1:0]               total;
  logic                             pop, final_word, load;

  assign final_word    = (left == CNT_W'(1));
  assign pop           = vld && out_ready;
  assign take          = !vld || (out_ready && final_word);
  assign load          = fire && (burst.count != '0);

  assign out_valid     = vld;
  assign out_byte      = shreg[0];
  assign out_frame_end = has_end && final_word;
  assign out_total     = total;
  assign out_last      = final_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= 1'b0;
      left <= '0;
    end else if (load) begin
      vld  <= 1'b1;
      left <= burst.count;
    end else if (pop) begin
      vld  <= !final_word;
      left <= left - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg   <= burst.bytes;
      has_end <= burst.has_end;
      total   <= burst.total;
    end else if (pop) begin
      shreg   <= {{BYTE_W{1'b0}}, shreg[BURST_MAX-1:1]};
    end
  end

endmodule
